>>> rtl/tcd_pkg.sv
// shared types and constants of the triac dimmer
package tcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned GATE_W = 3;
  localparam int unsigned CMP_W  = 15;
  localparam int unsigned BAR_W  = 5;
  localparam int unsigned LAMP_W = 3;

  localparam int unsigned COUNTS_PER_CODE = 16667 / 255;
  localparam int unsigned CODE_MAX        = 255;
  localparam int unsigned BUTTON_BIT      = 7;

  localparam logic [CMP_W-1:0]  FIRST_COMPARE = CMP_W'(8000);
  localparam logic [CMP_W-1:0]  LAST_COMPARE  = CMP_W'(CODE_MAX * COUNTS_PER_CODE);
  localparam logic [POS_W-1:0]  NO_TOUCH      = 7'h7F;
  localparam logic [BYTE_W-1:0] NO_BUTTON     = 8'hFF;

  typedef enum logic [1:0] {
    ACT_TOUCH   = 2'd0,
    ACT_COMPARE = 2'd1,
    ACT_PERIOD  = 2'd2
  } tcd_action_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] touch_byte;
  } tcd_item_t;

  typedef struct packed {
    logic [BAR_W-1:0]  left_bar;
    logic [BAR_W-1:0]  right_bar;
    logic [LAMP_W-1:0] button_lamps;
    logic              display_changed;
  } tcd_display_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate_mask;
    logic [CMP_W-1:0]  compare_value;
    tcd_display_t      display;
  } tcd_result_t;

endpackage

>>> rtl/tcd_item_if.sv
// input channel of the dimmer: event code and touch byte
interface tcd_item_if;
  import tcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [BYTE_W-1:0] touch_byte;

  modport source (output valid, action, touch_byte, input ready);
  modport sink   (input valid, action, touch_byte, output ready);
endinterface

>>> rtl/tcd_result_if.sv
// result channel of the dimmer: gates, compare value and display
interface tcd_result_if;
  import tcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [GATE_W-1:0] gate_mask;
  logic [CMP_W-1:0]  compare_value;
  logic [BAR_W-1:0]  left_bar;
  logic [BAR_W-1:0]  right_bar;
  logic [LAMP_W-1:0] button_lamps;
  logic              display_changed;

  modport source (output valid, gate_mask, compare_value, left_bar, right_bar,
                  button_lamps, display_changed, input ready);
  modport sink   (input valid, gate_mask, compare_value, left_bar, right_bar,
                  button_lamps, display_changed, output ready);
endinterface

>>> rtl/tcd_in_reg.sv
// input register stage of the dimmer
module tcd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  tcd_pkg::tcd_item_t item_i,
  input  logic               adv_i,
  output logic               valid_o,
  output tcd_pkg::tcd_item_t item_o
);
  import tcd_pkg::*;

  logic      valid_q;
  tcd_item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end
endmodule

>>> rtl/tcd_panel.sv
// touch decoding: selected button, slider positions, delays, bars and lamps
module tcd_panel #(
  parameter int unsigned CHANNELS = 3,
  parameter int unsigned LEVELS   = 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    fire_i,
  input  tcd_pkg::tcd_item_t                      item_i,
  output logic [CHANNELS-1:0][tcd_pkg::CMP_W-1:0] counts_o,
  output tcd_pkg::tcd_display_t                   display_o
);
  import tcd_pkg::*;

  localparam int unsigned ChW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LvlW     = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;
  localparam int unsigned CodeStep = CODE_MAX / LEVELS;
  localparam int unsigned LutDepth = 2 ** POS_W;
  localparam logic [ChW-1:0] ResetCh = ChW'((int'(NO_BUTTON) - 1) % CHANNELS);

  // channel of each button code, indexed by code minus one
  logic [ChW-1:0] chan_lut [LutDepth];
  for (genvar k = 0; k < LutDepth; k++) begin : g_lut
    assign chan_lut[k] = ChW'(k % CHANNELS);
  end

  logic [BYTE_W-1:0]                 sel_q, sel_d;
  logic [ChW-1:0]                    sel_ch_q, sel_ch_d;
  logic [CHANNELS-1:0][POS_W-1:0]    pos_q, pos_d;
  logic [CHANNELS-1:0][CMP_W-1:0]    cnt_q, cnt_d;
  logic [BAR_W-1:0]                  lbar_q, lbar_d, rbar_q, rbar_d;
  logic [LAMP_W-1:0]                 lamps_q, lamps_d;

  logic [POS_W-1:0] low;
  logic [ChW-1:0]   btn_ch, apply_ch;
  logic [POS_W-1:0] apply_val;
  logic             apply;
  logic [LvlW-1:0]  level;
  logic [BAR_W-1:0] bar;

  always_comb begin
    sel_d     = sel_q;
    sel_ch_d  = sel_ch_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    lbar_d    = lbar_q;
    rbar_d    = rbar_q;
    lamps_d   = lamps_q;
    low       = item_i.touch_byte[POS_W-1:0];
    btn_ch    = chan_lut[low - POS_W'(1)];
    apply     = 1'b0;
    apply_ch  = sel_ch_q;
    apply_val = low;

    case (tcd_action_e'(item_i.action))
      ACT_TOUCH: begin
        if (item_i.touch_byte[BUTTON_BIT]) begin
          // new nonzero button code: select it and reapply its stored position
          if (low != '0 && {1'b0, low} != sel_q) begin
            sel_d    = {1'b0, low};
            sel_ch_d = btn_ch;
            if (low <= POS_W'(LAMP_W)) begin
              lamps_d = LAMP_W'(1) << (low - POS_W'(1));
            end
            apply     = 1'b1;
            apply_ch  = btn_ch;
            apply_val = pos_q[btn_ch];
          end
        end else if (low != NO_TOUCH) begin
          apply = 1'b1;
        end
      end
      ACT_COMPARE: begin
      end
      ACT_PERIOD: begin
      end
      default: begin
      end
    endcase

    if (apply_val > POS_W'(LEVELS)) begin
      level = LvlW'(LEVELS);
    end else begin
      level = LvlW'(apply_val);
    end
    for (int k = 0; k < BAR_W; k++) begin
      bar[k] = (int'(level) > k);
    end

    if (apply) begin
      pos_d[apply_ch] = apply_val;
      cnt_d[apply_ch] = CMP_W'((LEVELS - int'(level)) * CodeStep * COUNTS_PER_CODE);
      if (int'(apply_ch) == 0) begin
        lbar_d = bar;
        rbar_d = '0;
      end else if (int'(apply_ch) == 1) begin
        lbar_d = bar;
        rbar_d = bar;
      end else if (int'(apply_ch) == 2) begin
        lbar_d = '0;
        rbar_d = bar;
      end
    end
  end

  assign counts_o  = cnt_q;
  assign display_o = '{left_bar: lbar_d, right_bar: rbar_d, button_lamps: lamps_d,
                       display_changed: apply};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= NO_BUTTON;
      sel_ch_q <= ResetCh;
      pos_q    <= '0;
      cnt_q    <= {CHANNELS{LAST_COMPARE}};
      lbar_q   <= '0;
      rbar_q   <= '0;
      lamps_q  <= '0;
    end else if (fire_i) begin
      sel_q    <= sel_d;
      sel_ch_q <= sel_ch_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      lbar_q   <= lbar_d;
      rbar_q   <= rbar_d;
      lamps_q  <= lamps_d;
    end
  end
endmodule

>>> rtl/tcd_phase.sv
// phase timer side: gate firing on compare match and next compare selection
module tcd_phase #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    fire_i,
  input  logic [1:0]                              action_i,
  input  logic [CHANNELS-1:0][tcd_pkg::CMP_W-1:0] counts_i,
  output logic [tcd_pkg::GATE_W-1:0]              gates_o,
  output logic [tcd_pkg::CMP_W-1:0]               compare_o
);
  import tcd_pkg::*;

  localparam int unsigned GateN = (CHANNELS < GATE_W) ? CHANNELS : GATE_W;

  logic [GATE_W-1:0] gates_q, gates_d, hit;
  logic [CMP_W-1:0]  next_q, next_d, min_above, min_all;

  always_comb begin
    gates_d   = gates_q;
    next_d    = next_q;
    hit       = '0;
    min_above = LAST_COMPARE;
    min_all   = LAST_COMPARE;
    for (int i = 0; i < GateN; i++) begin
      hit[i] = (counts_i[i] == next_q);
    end
    for (int i = 0; i < CHANNELS; i++) begin
      if (counts_i[i] > next_q && counts_i[i] < min_above) begin
        min_above = counts_i[i];
      end
      if (counts_i[i] < min_all) begin
        min_all = counts_i[i];
      end
    end

    case (tcd_action_e'(action_i))
      ACT_COMPARE: begin
        gates_d = gates_q | hit;
        // wrap to the earliest firing when nothing below the last compare lies later in the period
        next_d  = (min_above != LAST_COMPARE) ? min_above : min_all;
      end
      ACT_PERIOD: begin
        gates_d = '0;
      end
      ACT_TOUCH: begin
      end
      default: begin
      end
    endcase
  end

  assign gates_o   = gates_d;
  assign compare_o = next_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gates_q <= '0;
      next_q  <= FIRST_COMPARE;
    end else if (fire_i) begin
      gates_q <= gates_d;
      next_q  <= next_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_compare_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= LAST_COMPARE)
    else $error("compare value beyond last firing count");
`endif
endmodule

>>> rtl/tcd_out_reg.sv
// result register of the dimmer
module tcd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tcd_pkg::tcd_result_t result_i,
  input  logic                 ready_i,
  output logic                 can_take_o,
  output logic                 valid_o,
  output tcd_pkg::tcd_result_t result_o
);
  import tcd_pkg::*;

  logic        valid_q;
  tcd_result_t result_q;

  assign can_take_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign result_o   = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end
endmodule

>>> rtl/three_channel_triac_dimmer.sv
// top level of the three channel touch controlled triac phase dimmer
//
//   port      dir  payload                                           beat
//   item_i    in   action, touch_byte                                one event
//   result_o  out  gate_mask, compare_value, left_bar, right_bar,    one result
//                  button_lamps, display_changed
//
// one beat in gives one beat out; a beat is held in the input register, then
// processed and loaded into the result register, and a new beat is taken every
// cycle while the result side does not stall
// the throughput is set by the single pass of panel and phase logic between
// the two registers, with all channel compares done side by side
// reset puts the selected button at none, all positions at zero, all firing
// counts at the end of the period and the first compare at 8000
// a stalled result holds in the result register while one more beat can
// still wait in the input register
module three_channel_triac_dimmer #(
  parameter int unsigned CHANNELS = 3,
  parameter int unsigned LEVELS   = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcd_item_if.sink     item_i,
  tcd_result_if.source result_o
);
  import tcd_pkg::*;

  tcd_item_t                      item_d, item_q;
  logic                           s1_valid;
  logic                           out_can;
  logic                           fire;
  logic [CHANNELS-1:0][CMP_W-1:0] counts;
  tcd_display_t                   display_d;
  logic [GATE_W-1:0]              gates_d;
  logic [CMP_W-1:0]               compare_d;
  tcd_result_t                    result_d, result_q;

  assign item_d = '{action: item_i.action, touch_byte: item_i.touch_byte};

  // input register: holds one event until the result side can take it
  tcd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_i.valid),
    .ready_o (item_i.ready),
    .item_i  (item_d),
    .adv_i   (fire),
    .valid_o (s1_valid),
    .item_o  (item_q)
  );

  // the event is processed and state commits in the cycle it moves on
  assign fire = s1_valid && out_can;

  // touch bytes: button select, slider apply, delays and display
  tcd_panel #(
    .CHANNELS (CHANNELS),
    .LEVELS   (LEVELS)
  ) u_panel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_q),
    .counts_o  (counts),
    .display_o (display_d)
  );

  // timer events: gate firing and next compare scheduling
  tcd_phase #(
    .CHANNELS (CHANNELS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .action_i  (item_q.action),
    .counts_i  (counts),
    .gates_o   (gates_d),
    .compare_o (compare_d)
  );

  assign result_d = '{gate_mask: gates_d, compare_value: compare_d, display: display_d};

  // result register: decouples downstream stalls from the input side
  tcd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .result_i   (result_d),
    .ready_i    (result_o.ready),
    .can_take_o (out_can),
    .valid_o    (result_o.valid),
    .result_o   (result_q)
  );

  assign result_o.gate_mask       = result_q.gate_mask;
  assign result_o.compare_value   = result_q.compare_value;
  assign result_o.left_bar        = result_q.display.left_bar;
  assign result_o.right_bar       = result_q.display.right_bar;
  assign result_o.button_lamps    = result_q.display.button_lamps;
  assign result_o.display_changed = result_q.display.display_changed;

`ifndef NO_ASSERTIONS
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> result_o.valid)
    else $error("processed beat did not reach the result register");

  a_display_only_on_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_q.action != ACT_TOUCH) |=> !result_o.display_changed)
    else $error("display change reported for a timer event");

  a_period_clears_gates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_q.action == ACT_PERIOD) |=> (result_o.gate_mask == '0))
    else $error("period start left a gate on");
`endif
endmodule

>>> sim/three_channel_triac_dimmer_tb.sv
// self-checking testbench of the three channel triac dimmer: directed and random event beats
module three_channel_triac_dimmer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcd_pkg::*;

  localparam int unsigned DIM_CHANNELS = 3;
  localparam int unsigned DIM_LEVELS   = 5;
  localparam int unsigned CODE_STEP    = CODE_MAX / DIM_LEVELS;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam logic [7:0]  BUTTON_FLAG  = 8'h80;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  tcd_item_if   item_if ();
  tcd_result_if res_if ();

  three_channel_triac_dimmer #(
    .CHANNELS(DIM_CHANNELS),
    .LEVELS  (DIM_LEVELS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if)
  );

  // free running clock, 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // own copy of the dimmer state
  logic [7:0]  dim_button;
  logic [6:0]  dim_pos [DIM_CHANNELS];
  logic [7:0]  dim_code [DIM_CHANNELS];
  logic [14:0] dim_compare;
  logic [2:0]  dim_gates;
  logic [4:0]  dim_left;
  logic [4:0]  dim_right;
  logic [2:0]  dim_lamps;

  // gate and panel states still owed by the block, oldest first
  tcd_result_t panel_gate_q [$];

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic reset_dimmer_state();
    dim_button  = NO_BUTTON;
    for (int i = 0; i < DIM_CHANNELS; i++) begin
      dim_pos[i]  = '0;
      dim_code[i] = 8'(CODE_MAX);
    end
    dim_compare = FIRST_COMPARE;
    dim_gates   = '0;
    dim_left    = '0;
    dim_right   = '0;
    dim_lamps   = '0;
  endtask

  // slider channel follows the selected button, the no-button code wraps to channel 2
  function automatic int unsigned active_channel();
    return (int'(dim_button) - 1) % DIM_CHANNELS;
  endfunction

  // store a position, clamp to the level range, set delay code and bars
  task automatic apply_level(input int unsigned ch, input logic [6:0] value);
    int unsigned lvl;
    logic [4:0]  bar;
    lvl = (32'(value) > DIM_LEVELS) ? DIM_LEVELS : 32'(value);
    bar = 5'((32'd1 << lvl) - 1);
    dim_pos[ch]  = value;
    dim_code[ch] = 8'((DIM_LEVELS - lvl) * CODE_STEP);
    case (ch)
      0: begin
        dim_left  = bar;
        dim_right = '0;
      end
      1: begin
        dim_left  = bar;
        dim_right = bar;
      end
      2: begin
        dim_left  = '0;
        dim_right = bar;
      end
      default: ;
    endcase
  endtask

  // fire gates at the current count, then pick the next later firing or wrap around
  task automatic fire_compare();
    int unsigned cur;
    int unsigned nxt;
    int unsigned v;
    bit          found;
    cur   = 32'(dim_compare);
    nxt   = 32'(LAST_COMPARE);
    found = 1'b0;
    for (int i = 0; i < DIM_CHANNELS; i++) begin
      v = int'(dim_code[i]) * COUNTS_PER_CODE;
      if (v == cur) dim_gates[i] = 1'b1;
    end
    for (int i = 0; i < DIM_CHANNELS; i++) begin
      v = int'(dim_code[i]) * COUNTS_PER_CODE;
      if (v > cur && v < nxt) begin
        nxt   = v;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < DIM_CHANNELS; i++) begin
        v = int'(dim_code[i]) * COUNTS_PER_CODE;
        if (v < nxt) nxt = v;
      end
    end
    dim_compare = 15'(nxt);
  endtask

  // advance the dimmer state by one event and give the result it reports
  task automatic step_dimmer(input logic [1:0] act, input logic [7:0] raw,
                             output tcd_result_t res);
    logic [6:0]  low;
    int unsigned ch;
    logic        changed;
    low     = raw[6:0];
    changed = 1'b0;
    if (act == ACT_TOUCH) begin
      if (raw[BUTTON_BIT]) begin
        // zero and repeated button codes are dropped
        if (low != 0 && {1'b0, low} != dim_button) begin
          dim_button = {1'b0, low};
          if (low >= 1 && low <= 3) dim_lamps = 3'(1 << (low - 1));
          ch = active_channel();
          apply_level(ch, dim_pos[ch]);
          changed = 1'b1;
        end
      end else if (low != NO_TOUCH) begin
        apply_level(active_channel(), low);
        changed = 1'b1;
      end
    end else if (act == ACT_COMPARE) begin
      fire_compare();
    end else if (act == ACT_PERIOD) begin
      dim_gates = '0;
    end
    res.gate_mask                = dim_gates;
    res.compare_value            = dim_compare;
    res.display.left_bar         = dim_left;
    res.display.right_bar        = dim_right;
    res.display.button_lamps     = dim_lamps;
    res.display.display_changed  = changed;
  endtask

  // send one event beat after a random gap and log what it should produce
  task automatic send_event(input logic [1:0] act, input logic [7:0] raw);
    int unsigned gap;
    tcd_result_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.action     <= act;
    item_if.touch_byte <= raw;
    do @(posedge clk_i); while (!item_if.ready);
    step_dimmer(act, raw, res);
    panel_gate_q.push_back(res);
    beats_sent++;
  endtask

  // hold the input side until every owed result has come out
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (panel_gate_q.size() != 0) @(posedge clk_i);
  endtask

  // slider byte, mostly inside the level range, now and then anywhere
  function automatic logic [7:0] slider_byte();
    if ($urandom_range(0, 5) == 0) return {1'b0, 7'($urandom_range(0, 127))};
    return 8'($urandom_range(0, DIM_LEVELS + 1));
  endfunction

  // button byte, mostly the three lit buttons
  function automatic logic [7:0] button_byte();
    if ($urandom_range(0, 4) == 0) return BUTTON_FLAG | 8'($urandom_range(0, 127));
    return BUTTON_FLAG | 8'($urandom_range(1, 3));
  endfunction

  // every event kind plus the corner cases of the touch decoding
  task automatic test_directed();
    send_event(ACT_UNUSED, 8'hFF);           // unused action reports state only
    send_event(ACT_TOUCH, 8'h03);            // slider before any button goes to channel 2
    send_event(ACT_TOUCH, 8'h7F);            // no-touch code is ignored
    send_event(ACT_TOUCH, 8'h80);            // button code zero is ignored
    send_event(ACT_TOUCH, 8'h81);            // left button
    send_event(ACT_TOUCH, 8'h81);            // repeated button is ignored
    send_event(ACT_TOUCH, 8'h05);            // full level, zero delay
    send_event(ACT_COMPARE, 8'h00);
    send_event(ACT_COMPARE, 8'hFF);
    send_event(ACT_TOUCH, 8'h82);            // middle button
    send_event(ACT_TOUCH, 8'h02);
    send_event(ACT_TOUCH, 8'h83);            // right button
    send_event(ACT_TOUCH, 8'h7E);            // largest slider value clamps
    send_event(ACT_TOUCH, 8'h00);            // lowest slider value
    send_event(ACT_COMPARE, 8'h55);
    send_event(ACT_COMPARE, 8'hAA);
    send_event(ACT_COMPARE, 8'h00);
    send_event(ACT_TOUCH, 8'hFF);            // button above three leaves lamps alone
    send_event(ACT_TOUCH, 8'h04);
    send_event(ACT_TOUCH, 8'h84);
    send_event(ACT_PERIOD, 8'h00);           // period start drops all gates
    send_event(ACT_COMPARE, 8'h00);
    send_event(ACT_COMPARE, 8'h00);
    send_event(ACT_PERIOD, 8'hFF);
    send_event(ACT_UNUSED, 8'h00);
  endtask

  // well formed half periods: pick and dim, then walk the compare schedule
  task automatic test_firing_cycles(input int unsigned beats);
    int unsigned target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      if ($urandom_range(0, 2) == 0) send_event(ACT_TOUCH, button_byte());
      repeat ($urandom_range(0, 2)) send_event(ACT_TOUCH, slider_byte());
      send_event(ACT_PERIOD, 8'($urandom));
      repeat ($urandom_range(1, 5)) begin
        send_event(ACT_COMPARE, 8'($urandom));
        // stray touch inside the period now and then
        if ($urandom_range(0, 7) == 0) send_event(ACT_TOUCH, 8'($urandom));
      end
    end
  endtask

  // sender holds off until the block is empty, several times over
  task automatic test_drain_pauses(input int unsigned rounds);
    repeat (rounds) begin
      repeat ($urandom_range(3, 12)) send_event(2'($urandom_range(0, 2)), 8'($urandom));
      wait_drained();
    end
  endtask

  // any action code and any byte
  task automatic test_random_noise(input int unsigned beats);
    repeat (beats) send_event(2'($urandom), 8'($urandom));
  endtask

  // back to back beats on both sides with no idling
  task automatic test_steady_stream(input int unsigned beats);
    no_gaps = 1'b1;
    test_firing_cycles(beats);
    no_gaps = 1'b0;
  endtask

  // result side: random stall before each beat, check against the oldest owed result
  initial begin
    int unsigned stall;
    tcd_result_t want;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (panel_gate_q.size() == 0) begin
        report_mismatch("result beat with nothing owed");
      end else begin
        want = panel_gate_q.pop_front();
        if (res_if.gate_mask !== want.gate_mask)
          report_mismatch($sformatf("gate_mask got %0d expected %0d",
                                    res_if.gate_mask, want.gate_mask));
        if (res_if.compare_value !== want.compare_value)
          report_mismatch($sformatf("compare_value got %0d expected %0d",
                                    res_if.compare_value, want.compare_value));
        if (res_if.left_bar !== want.display.left_bar)
          report_mismatch($sformatf("left_bar got %0d expected %0d",
                                    res_if.left_bar, want.display.left_bar));
        if (res_if.right_bar !== want.display.right_bar)
          report_mismatch($sformatf("right_bar got %0d expected %0d",
                                    res_if.right_bar, want.display.right_bar));
        if (res_if.button_lamps !== want.display.button_lamps)
          report_mismatch($sformatf("button_lamps got %0d expected %0d",
                                    res_if.button_lamps, want.display.button_lamps));
        if (res_if.display_changed !== want.display.display_changed)
          report_mismatch($sformatf("display_changed got %0d expected %0d",
                                    res_if.display_changed,
                                    want.display.display_changed));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    item_if.valid      <= 1'b0;
    item_if.action     <= ACT_TOUCH;
    item_if.touch_byte <= '0;
    rst_ni             <= 1'b0;
    reset_dimmer_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_drained();
    test_firing_cycles(850);
    test_drain_pauses(12);
    test_random_noise(450);
    test_steady_stream(250);

    // let the pipeline empty, then idle for DRAIN_CYCLES to catch stray beats
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> three_channel_triac_dimmer.f
rtl/tcd_pkg.sv
rtl/tcd_item_if.sv
rtl/tcd_result_if.sv
rtl/tcd_in_reg.sv
rtl/tcd_panel.sv
rtl/tcd_phase.sv
rtl/tcd_out_reg.sv
rtl/three_channel_triac_dimmer.sv
sim/three_channel_triac_dimmer_tb.sv
